@@ sv/mt_pkg.sv @@
// Package for the MT19937 generator: sizes, constants, codes and the cell control word.
// Used by mt_cell, mt_out_stage and mt19937_generator; depends on nothing.
`timescale 1ns / 1ps

package mt_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int WORD_W       = 32;
  localparam int IDX_W        = $clog2(STATE_WORDS);

  localparam int EFF_OFFSET = (TWIST_OFFSET > STATE_WORDS) ? STATE_WORDS / 2 : TWIST_OFFSET;
  localparam int FAR_CELL   = (EFF_OFFSET == STATE_WORDS) ? 0 : EFF_OFFSET;

  localparam logic [WORD_W-1:0] MATRIX_A = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc60000;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef struct packed {
    logic              shift;
    logic              load;
    logic [WORD_W-1:0] load_word;
  } cell_ctrl_t;

endpackage

@@ sv/mt_cell.sv @@
// One cell of the state ring: holds one 32-bit state word.
// Takes its neighbor's word on a shift or a seed word on a load; uses mt_pkg.
`timescale 1ns / 1ps

module mt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mt_pkg::cell_ctrl_t        ctrl_i,
  input  logic                      load_en_i,
  input  logic [mt_pkg::WORD_W-1:0] shift_word_i,
  output logic [mt_pkg::WORD_W-1:0] word_o
);
  import mt_pkg::*;

  logic [WORD_W-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.load && load_en_i) begin
      word_d = ctrl_i.load_word;
    end else if (ctrl_i.shift) begin
      word_d = shift_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

@@ sv/mt_out_stage.sv @@
// Output register of the MT19937 generator: tempers a twisted word and holds it
// until taken. Uses mt_pkg.
`timescale 1ns / 1ps

module mt_out_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [mt_pkg::WORD_W-1:0] word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [mt_pkg::WORD_W-1:0] random_value_o
);
  import mt_pkg::*;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  logic              valid_q, valid_d;
  logic [WORD_W-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = temper(word_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o    = valid_q;
  assign random_value_o = data_q;

endmodule

@@ sv/mt19937_generator.sv @@
// MT19937 generator: a drawn word is output the cycle after; one word per cycle unless stalled.
// State is a ring of cells that shifts one place per draw; the twist taps sit at fixed cells.
// A load that leaves the ring out of phase starts a realign pass that shifts it into phase,
// during which no word is accepted; draws then restart at state word 0.
// Reset clears all state words to zero, the load position to 0 and marks a twist pending.
// Depends on mt_pkg, mt_cell and mt_out_stage.
`timescale 1ns / 1ps

module mt19937_generator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      kind_i,
  input  logic [mt_pkg::WORD_W-1:0] load_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [mt_pkg::WORD_W-1:0] random_value_o
);
  import mt_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  logic [WORD_W-1:0] words [STATE_WORDS];
  logic [STATE_WORDS-1:0] load_en;

  logic [IDX_W-1:0] rot_q, rot_d;
  logic [IDX_W-1:0] lp_q, lp_d;
  logic             pending_q, pending_d;

  logic             aligning, in_acc, draw_acc, load_acc;
  logic [IDX_W-1:0] lp_cell;
  logic [IDX_W:0]   lp_wrap;
  logic [WORD_W-1:0] h, twisted, tail;
  cell_ctrl_t       ctrl;

  assign aligning   = pending_q && (rot_q != '0);
  assign in_stall_o = aligning || (out_valid_o && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign draw_acc   = in_acc && (kind_i == KIND_DRAW);
  assign load_acc   = in_acc && (kind_i == KIND_LOAD);

  assign lp_wrap = {1'b0, lp_q} + (IDX_W + 1)'(STATE_WORDS) - {1'b0, rot_q};
  assign lp_cell = (lp_q >= rot_q) ? (lp_q - rot_q) : lp_wrap[IDX_W-1:0];

  assign h       = {words[0][WORD_W-1], words[1][WORD_W-2:0]};
  assign twisted = words[FAR_CELL] ^ (h >> 1) ^ (h[0] ? MATRIX_A : '0);
  assign tail    = aligning ? words[0] : twisted;

  assign ctrl.shift     = draw_acc || aligning;
  assign ctrl.load      = load_acc;
  assign ctrl.load_word = load_value_i;

  for (genvar j = 0; j < STATE_WORDS; j++) begin : g_cell
    logic [WORD_W-1:0] shift_word;
    if (j == STATE_WORDS - 1) begin : g_tail
      assign shift_word = tail;
    end else begin : g_mid
      assign shift_word = words[j + 1];
    end
    assign load_en[j] = (lp_cell == IDX_W'(j));
    mt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_en_i   (load_en[j]),
      .shift_word_i(shift_word),
      .word_o      (words[j])
    );
  end

  always_comb begin
    rot_d     = rot_q;
    lp_d      = lp_q;
    pending_d = pending_q;
    if (ctrl.shift) begin
      rot_d = (rot_q == LAST_IDX) ? '0 : rot_q + 1'b1;
    end
    if (load_acc) begin
      lp_d      = (lp_q == LAST_IDX) ? '0 : lp_q + 1'b1;
      pending_d = 1'b1;
    end else if (draw_acc) begin
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q     <= '0;
      lp_q      <= '0;
      pending_q <= 1'b1;
    end else begin
      rot_q     <= rot_d;
      lp_q      <= lp_d;
      pending_q <= pending_d;
    end
  end

  mt_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (draw_acc),
    .word_i        (twisted),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_value_o(random_value_o)
  );

  a_align_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aligning |-> in_stall_o)
    else $error("input taken during realign pass");

  a_draw_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_acc |=> out_valid_o)
    else $error("draw produced no word");

  a_load_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> pending_q)
    else $error("load did not mark twist pending");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rot_q <= LAST_IDX) && (lp_q <= LAST_IDX))
    else $error("ring position out of range");

  a_draw_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (draw_acc && pending_q) |-> (rot_q == '0))
    else $error("draw after load while ring out of phase");

endmodule
